// ===== hw/rtl/spcn_pkg.sv =====
// ----------------------------------------------------------------------------
// spcn_pkg
// Shared widths, constants and types of the scan packet cone-nearest block.
// ----------------------------------------------------------------------------
package spcn_pkg;

	localparam int ANGLE_W = 15;
	localparam int DIST_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Distance mark for "no sample in cone this revolution"
	localparam logic [DIST_W-1:0] EMPTY_DISTANCE = 16'd39996;

	// Configuration reset values
	localparam logic [ANGLE_W-1:0] CONE_RIGHT_RST = 15'd1920;
	localparam logic [ANGLE_W-1:0] CONE_LEFT_RST  = 15'd21120;
	localparam logic [DIST_W-1:0]  RANGE_RST      = 16'd4000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CONE_RIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONE_LEFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE      = 2'd2;

	// Sync codes of the first packet byte
	localparam logic [1:0] SYNC_START = 2'b01;
	localparam logic [1:0] SYNC_CONT  = 2'b10;

	typedef struct packed {
		logic [ANGLE_W-1:0] cone_right_limit;
		logic [ANGLE_W-1:0] cone_left_start;
		logic [DIST_W-1:0]  range_limit;
	} cfg_t;

	// One framed measurement packet
	typedef struct packed {
		logic               start;
		logic               quality_ok;
		logic [ANGLE_W-1:0] angle;
		logic [DIST_W-1:0]  distance;
	} pkt_t;

endpackage

// ===== hw/rtl/spcn_byte_if.sv =====
// ----------------------------------------------------------------------------
// spcn_byte_if
// Valid/ready channel carrying one raw byte from the scanner link.
// ----------------------------------------------------------------------------
interface spcn_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/spcn_result_if.sv =====
// ----------------------------------------------------------------------------
// spcn_result_if
// Valid/ready channel carrying the nearest in-cone sample of a revolution.
// ----------------------------------------------------------------------------
interface spcn_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] nearest_distance;
	logic [14:0] nearest_angle;

	modport source (output valid, output nearest_distance, output nearest_angle,
		input ready);
	modport sink   (input valid, input nearest_distance, input nearest_angle,
		output ready);
endinterface

// ===== hw/rtl/spcn_framer.sv =====
// ----------------------------------------------------------------------------
// spcn_framer
// Hunts for sync, collects the five packet bytes and registers each
// completed packet into the stage-1 register.
// ----------------------------------------------------------------------------
module spcn_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [spcn_pkg::BYTE_W-1:0] rx_byte,
	input  logic                        pop,
	output logic                        pkt_valid_s1,
	output spcn_pkg::pkt_t              pkt_s1
);
	import spcn_pkg::*;

	typedef enum logic [2:0] {
		POS_HUNT    = 3'd0,
		POS_CHECK   = 3'd1,
		POS_ANGLE   = 3'd2,
		POS_DIST_LO = 3'd3,
		POS_DIST_HI = 3'd4
	} pos_t;

	pos_t              pos_q;
	pos_t              pos_d;
	logic [BYTE_W-1:0] held_q [4];
	logic              sync_ok;
	logic              last;
	pkt_t              pkt_d;

	assign sync_ok = (rx_byte[1:0] == SYNC_START) || (rx_byte[1:0] == SYNC_CONT);

	// Next frame position; unused codes behave as the last byte
	always_comb begin
		last  = 1'b0;
		pos_d = pos_q;
		case (pos_q)
			POS_HUNT:    pos_d = sync_ok ? POS_CHECK : POS_HUNT;
			POS_CHECK: begin
				if (rx_byte[0])
					pos_d = POS_ANGLE;
				else
					pos_d = sync_ok ? POS_CHECK : POS_HUNT;
			end
			POS_ANGLE:   pos_d = POS_DIST_LO;
			POS_DIST_LO: pos_d = POS_DIST_HI;
			default: begin
				last  = 1'b1;
				pos_d = POS_HUNT;
			end
		endcase
	end

	// Packet fields as the last byte arrives
	always_comb begin
		pkt_d.start      = held_q[0][0];
		pkt_d.quality_ok = |held_q[0][7:2];
		pkt_d.angle      = {held_q[2], held_q[1][7:1]};
		pkt_d.distance   = {rx_byte, held_q[3]};
	end

	// Frame position and stage-1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HUNT;
			pkt_valid_s1 <= 1'b0;
		end else begin
			if (take)
				pos_q <= pos_d;
			if (take && last)
				pkt_valid_s1 <= 1'b1;
			else if (pop)
				pkt_valid_s1 <= 1'b0;
		end
	end

	// Held bytes and stage-1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			case (pos_q)
				POS_HUNT:    held_q[0] <= rx_byte;
				POS_CHECK: begin
					if (rx_byte[0])
						held_q[1] <= rx_byte;
					else
						held_q[0] <= rx_byte;
				end
				POS_ANGLE:   held_q[2] <= rx_byte;
				POS_DIST_LO: held_q[3] <= rx_byte;
				default:     pkt_s1    <= pkt_d;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A packet waiting in stage 1 is never lost
	a_pkt_kept: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid_s1 && !pop |=> pkt_valid_s1)
		else $error("stage-1 packet dropped");
	// A completed packet always lands in stage 1
	a_pkt_load: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> pkt_valid_s1)
		else $error("completed packet not registered");
	// Bytes are only taken when stage 1 can accept a packet
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take && last && pkt_valid_s1 |-> pop)
		else $error("stage-1 overrun");
`endif

endmodule

// ===== hw/rtl/spcn_tracker.sv =====
// ----------------------------------------------------------------------------
// spcn_tracker
// Keeps the nearest valid in-cone sample of the current revolution and
// hands it to the result register at each start-of-revolution packet.
// ----------------------------------------------------------------------------
module spcn_tracker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spcn_pkg::cfg_t        cfg,
	input  logic                  pkt_valid_s1,
	input  spcn_pkg::pkt_t        pkt_s1,
	output logic                  pop,
	spcn_result_if.source         result
);
	import spcn_pkg::*;

	logic [DIST_W-1:0]  best_dist_q;
	logic [ANGLE_W-1:0] best_angle_q;
	logic               res_valid_q;
	logic [DIST_W-1:0]  res_dist_q;
	logic [ANGLE_W-1:0] res_angle_q;
	logic               slot_free;
	logic               emit;
	logic               in_cone;
	logic               sample_ok;
	logic [DIST_W-1:0]  cmp_dist;
	logic               take_sample;

	// A start packet needs the result slot; other packets always pass
	assign slot_free = !res_valid_q || result.ready;
	assign pop       = pkt_valid_s1 && (!pkt_s1.start || slot_free);
	assign emit      = pop && pkt_s1.start;

	// Sample qualification against cone and range
	assign in_cone   = (pkt_s1.angle <= cfg.cone_right_limit) ||
		(pkt_s1.angle >= cfg.cone_left_start);
	assign sample_ok = pkt_s1.quality_ok && (pkt_s1.distance != '0) &&
		(pkt_s1.distance <= cfg.range_limit) && in_cone;
	// Tracker is cleared before a start packet's own sample is weighed
	assign cmp_dist    = pkt_s1.start ? EMPTY_DISTANCE : best_dist_q;
	assign take_sample = sample_ok && (pkt_s1.distance < cmp_dist);

	// Nearest-sample tracker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q  <= EMPTY_DISTANCE;
			best_angle_q <= '0;
		end else if (pop) begin
			if (take_sample) begin
				best_dist_q  <= pkt_s1.distance;
				best_angle_q <= pkt_s1.angle;
			end else if (pkt_s1.start) begin
				best_dist_q  <= EMPTY_DISTANCE;
				best_angle_q <= '0;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_dist_q  <= best_dist_q;
			res_angle_q <= best_angle_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.nearest_distance = res_dist_q;
	assign result.nearest_angle    = res_angle_q;

`ifndef SYNTHESIS
	// An empty tracker always holds a zero angle
	a_empty_angle: assert property (@(posedge clk) disable iff (!arst_n)
		best_dist_q == EMPTY_DISTANCE |-> best_angle_q == '0)
		else $error("empty tracker with nonzero angle");
	// Tracked distance never exceeds the empty mark
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_dist_q <= EMPTY_DISTANCE)
		else $error("tracked distance beyond empty mark");
	// A start packet presents a result in the next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> res_valid_q)
		else $error("start packet produced no result");
`endif

endmodule

// ===== hw/rtl/scan_packet_cone_nearest.sv =====
// ----------------------------------------------------------------------------
// scan_packet_cone_nearest
// Frames 5-byte scanner packets and reports, once per revolution, the
// nearest valid sample inside a configurable forward cone.
// ----------------------------------------------------------------------------
//  channel  dir  request                 handshake
//  rx       in   rx_byte (8b)            rx.valid / rx.ready
//  result   out  nearest_distance (16b)  result.valid / result.ready
//                nearest_angle (15b)
//  cfg      in   cfg_index, cfg_data     cfg_we, no back-pressure
//
// One byte per cycle is taken while rx.ready is high. A completed packet
// waits in the stage-1 register; a start-of-revolution packet moves the previous best
// into the result register as it leaves stage 1, and the result register presents it.
// rx.ready drops only while a start packet waits for a full result register.
// Reset clears framing, the tracker (empty mark) and the registers' defaults.
// ----------------------------------------------------------------------------
module scan_packet_cone_nearest (
	input  logic                            clk,
	input  logic                            arst_n,
	spcn_byte_if.sink                       rx,
	spcn_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [spcn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spcn_pkg::CFG_DATA_W-1:0] cfg_data
);
	import spcn_pkg::*;

	cfg_t cfg_q;
	logic take;
	logic pop;
	logic pkt_valid_s1;
	pkt_t pkt_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cone_right_limit <= CONE_RIGHT_RST;
			cfg_q.cone_left_start  <= CONE_LEFT_RST;
			cfg_q.range_limit      <= RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONE_RIGHT: cfg_q.cone_right_limit <= cfg_data[ANGLE_W-1:0];
				CFG_CONE_LEFT:  cfg_q.cone_left_start  <= cfg_data[ANGLE_W-1:0];
				CFG_RANGE:      cfg_q.range_limit      <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Input flow control: stage 1 empty or draining
	assign rx.ready = !pkt_valid_s1 || pop;
	assign take     = rx.valid && rx.ready;

	spcn_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rx_byte      (rx.rx_byte),
		.pop          (pop),
		.pkt_valid_s1 (pkt_valid_s1),
		.pkt_s1       (pkt_s1)
	);

	spcn_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pkt_valid_s1 (pkt_valid_s1),
		.pkt_s1       (pkt_s1),
		.pop          (pop),
		.result       (result)
	);

endmodule
